// File: sv/crz_pkg.sv
// Shared types and constants for the circle rasterizer.
// No dependencies; every other file of the block imports this package.

package crz_pkg;

	localparam int COORD_W  = 16;
	localparam int RADIUS_W = 15;
	localparam int DEC_W    = 20;
	localparam int COLOR_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int OCT_W    = 3;

	// Decision-term constants of the midpoint walk.
	localparam logic signed [DEC_W-1:0] DEC_INIT    = 20'sd3;
	localparam logic signed [DEC_W-1:0] DEC_INC_IN  = 20'sd6;
	localparam logic signed [DEC_W-1:0] DEC_INC_OUT = 20'sd10;

	localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 16'd240;
	localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 16'd320;
	localparam logic [COLOR_W-1:0] DRAW_COLOR_RST    = 16'd0;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCREEN_WIDTH  = 2'd0,
		CFG_SCREEN_HEIGHT = 2'd1,
		CFG_DRAW_COLOR    = 2'd2
	} cfg_idx_t;

	typedef enum logic [OCT_W-1:0] {
		OCT_0 = 3'd0,
		OCT_1 = 3'd1,
		OCT_2 = 3'd2,
		OCT_3 = 3'd3,
		OCT_4 = 3'd4,
		OCT_5 = 3'd5,
		OCT_6 = 3'd6,
		OCT_7 = 3'd7
	} oct_t;

	// One point of the walk: centre, the two offsets and the final mark.
	typedef struct packed {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] ox;
		logic [COORD_W-1:0] oc;
		logic               fin;
	} point_t;

	// Live configuration seen by the pixel stage.
	typedef struct packed {
		logic [COORD_W-1:0] width;
		logic [COORD_W-1:0] height;
		logic [COLOR_W-1:0] color;
	} cfg_t;

endpackage

// File: sv/crz_if.sv
// Valid/ready channel interfaces of the circle rasterizer: command in, pixel out.
// Depends on crz_pkg for field widths.

interface crz_cmd_if;
	import crz_pkg::*;

	logic                valid;
	logic                ready;
	logic                op;
	logic [COORD_W-1:0]  center_x;
	logic [COORD_W-1:0]  center_y;
	logic [RADIUS_W-1:0] radius;
	logic                filled;

	modport source (output valid, op, center_x, center_y, radius, filled, input ready);
	modport sink   (input valid, op, center_x, center_y, radius, filled, output ready);
endinterface

interface crz_pix_if;
	import crz_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic               visible;
	logic [COLOR_W-1:0] color;
	logic               last;

	modport source (output valid, pixel_x, pixel_y, visible, color, last, input ready);
	modport sink   (input valid, pixel_x, pixel_y, visible, color, last, output ready);
endinterface

// File: sv/crz_walk.sv
// Midpoint circle state: loads a circle on start and advances one point or
// span position per step transfer. Depends on crz_pkg.

module crz_walk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic                          op,
	input  logic [crz_pkg::COORD_W-1:0]   center_x,
	input  logic [crz_pkg::COORD_W-1:0]   center_y,
	input  logic [crz_pkg::RADIUS_W-1:0]  radius,
	input  logic                          filled,
	output logic                          pt_load,
	output crz_pkg::point_t               pt
);
	import crz_pkg::*;

	logic                    active_q;
	logic                    fill_q;
	logic [COORD_W-1:0]      origin_x_q;
	logic [COORD_W-1:0]      origin_y_q;
	logic [COORD_W-1:0]      step_x_q;
	logic [COORD_W-1:0]      step_y_q;
	logic [COORD_W-1:0]      span_q;
	logic signed [DEC_W-1:0] dec_q;

	logic [COORD_W:0]        nspan;
	logic                    adv;
	logic signed [DEC_W-1:0] inc_in;
	logic signed [DEC_W-1:0] inc_out;
	logic signed [DEC_W-1:0] dec_nx;
	logic                    y_dec;
	logic [COORD_W:0]        nx;
	logic [COORD_W:0]        ny;
	logic                    fin;
	logic                    is_step;

	assign is_step = (op_t'(op) == OP_STEP);
	assign nspan   = {1'b0, span_q} + 17'd1;
	assign adv     = fill_q ? (nspan > {1'b0, step_y_q}) : 1'b1;

	// 4x + 6 and 4(x - y) + 10; the true values fit comfortably in 20 bits.
	assign inc_in  = $signed({2'b00, step_x_q, 2'b00}) + DEC_INC_IN;
	assign inc_out = $signed(({4'b0000, step_x_q} - {4'b0000, step_y_q}) << 2) + DEC_INC_OUT;
	assign y_dec   = !dec_q[DEC_W-1];
	assign dec_nx  = dec_q + (y_dec ? inc_out : inc_in);

	// Signed 17-bit compare so that y dropping below zero finishes the circle.
	assign nx  = {1'b0, step_x_q} + 17'd1;
	assign ny  = {1'b0, step_y_q} - {16'd0, y_dec};
	assign fin = adv && ($signed(nx) > $signed(ny));

	assign pt_load = fire && is_step && active_q;
	assign pt.cx   = origin_x_q;
	assign pt.cy   = origin_y_q;
	assign pt.ox   = step_x_q;
	assign pt.oc   = fill_q ? span_q : step_y_q;
	assign pt.fin  = fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			fill_q     <= 1'b0;
			origin_x_q <= '0;
			origin_y_q <= '0;
			step_x_q   <= '0;
			step_y_q   <= '0;
			span_q     <= '0;
			dec_q      <= '0;
		end else if (fire && !is_step) begin
			active_q   <= 1'b1;
			fill_q     <= filled;
			origin_x_q <= center_x;
			origin_y_q <= center_y;
			step_x_q   <= '0;
			step_y_q   <= {1'b0, radius};
			span_q     <= '0;
			dec_q      <= DEC_INIT - $signed({4'b0000, radius, 1'b0});
		end else if (pt_load) begin
			if (adv) begin
				dec_q    <= dec_nx;
				step_x_q <= nx[COORD_W-1:0];
				step_y_q <= ny[COORD_W-1:0];
				span_q   <= nx[COORD_W-1:0];
			end else begin
				span_q   <= nspan[COORD_W-1:0];
			end
			if (fin) begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/crz_emit.sv
// Holds one walk point and sends its eight symmetric pixels, one per cycle while
// the output is not stalled, through an output register. Depends on crz_pkg.

module crz_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pt_load,
	input  crz_pkg::point_t               pt,
	input  crz_pkg::cfg_t                 cfg,
	output logic                          take,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [crz_pkg::COORD_W-1:0]   pixel_x,
	output logic [crz_pkg::COORD_W-1:0]   pixel_y,
	output logic                          visible,
	output logic [crz_pkg::COLOR_W-1:0]   color,
	output logic                          last
);
	import crz_pkg::*;

	point_t             pt_q;
	logic               pv_q;
	logic [OCT_W-1:0]   idx_q;
	logic               ov_q;
	logic [COORD_W-1:0] px_q;
	logic [COORD_W-1:0] py_q;
	logic               vis_q;
	logic [COLOR_W-1:0] col_q;
	logic               last_q;

	logic               adv_out;
	logic               send;
	logic               done;
	logic [COORD_W-1:0] xo;
	logic [COORD_W-1:0] yo;
	logic               xneg;
	logic               yneg;
	logic [COORD_W-1:0] px;
	logic [COORD_W-1:0] py;

	assign adv_out = !ov_q || out_ready;
	assign send    = adv_out && pv_q;
	assign done    = send && (oct_t'(idx_q) == OCT_7);
	assign take    = !pv_q || done;

	// Pick offsets and signs for the current octant.
	always_comb begin
		xo = pt_q.ox; yo = pt_q.oc; xneg = 1'b0; yneg = 1'b0;
		case (oct_t'(idx_q))
			OCT_0: begin xo = pt_q.ox; yo = pt_q.oc; xneg = 1'b0; yneg = 1'b0; end
			OCT_1: begin xo = pt_q.ox; yo = pt_q.oc; xneg = 1'b1; yneg = 1'b0; end
			OCT_2: begin xo = pt_q.oc; yo = pt_q.ox; xneg = 1'b1; yneg = 1'b0; end
			OCT_3: begin xo = pt_q.oc; yo = pt_q.ox; xneg = 1'b1; yneg = 1'b1; end
			OCT_4: begin xo = pt_q.ox; yo = pt_q.oc; xneg = 1'b1; yneg = 1'b1; end
			OCT_5: begin xo = pt_q.ox; yo = pt_q.oc; xneg = 1'b0; yneg = 1'b1; end
			OCT_6: begin xo = pt_q.oc; yo = pt_q.ox; xneg = 1'b0; yneg = 1'b1; end
			OCT_7: begin xo = pt_q.oc; yo = pt_q.ox; xneg = 1'b0; yneg = 1'b0; end
			default: begin xo = pt_q.ox; yo = pt_q.oc; xneg = 1'b0; yneg = 1'b0; end
		endcase
	end

	assign px = xneg ? (pt_q.cx - xo) : (pt_q.cx + xo);
	assign py = yneg ? (pt_q.cy - yo) : (pt_q.cy + yo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q  <= 1'b0;
			idx_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (pt_load) begin
				pv_q  <= 1'b1;
				idx_q <= '0;
			end else if (send) begin
				idx_q <= idx_q + 3'd1;
				if (done) begin
					pv_q <= 1'b0;
				end
			end
			if (adv_out) begin
				ov_q <= pv_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pt_load) begin
			pt_q <= pt;
		end
		if (send) begin
			px_q   <= px;
			py_q   <= py;
			vis_q  <= (px < cfg.width) && (py < cfg.height);
			col_q  <= cfg.color;
			last_q <= pt_q.fin && (oct_t'(idx_q) == OCT_7);
		end
	end

	assign out_valid = ov_q;
	assign pixel_x   = px_q;
	assign pixel_y   = py_q;
	assign visible   = vis_q;
	assign color     = col_q;
	assign last      = last_q;

endmodule

// File: sv/circle_rasterizer_core.sv
// Top level of the midpoint circle rasterizer: configuration registers,
// the circle walk and the pixel emitter. Depends on crz_pkg, crz_if, crz_walk, crz_emit.
//
//   channel | role   | transfer carries
//   --------+--------+-----------------------------------------------------
//   cmd     | sink   | op, center_x, center_y, radius, filled
//   pix     | source | pixel_x, pixel_y, visible, color, last
//   cfg     | write  | cfg_we, cfg_index, cfg_wdata (width, height, color)
//
// A start transfer loads a new circle and yields no pixel; a step transfer while
// a circle is active yields eight pixels, one per cycle while the output is not
// stalled, so a steady stream of steps is limited by the single pixel output
// port. The step after a point is taken in the cycle its eighth pixel enters
// the output register. Output stalls back up through the point buffer to
// cmd.ready. Reset clears the walk state and restores the screen defaults of
// 240 by 320 with color zero.

module circle_rasterizer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [crz_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [crz_pkg::COORD_W-1:0]   cfg_wdata,
	crz_cmd_if.sink                       cmd,
	crz_pix_if.source                     pix
);
	import crz_pkg::*;

	cfg_t   cfg_q;
	logic   cmd_fire;
	logic   take;
	logic   pt_load;
	point_t pt;

	// Configuration registers; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= SCREEN_WIDTH_RST;
			cfg_q.height <= SCREEN_HEIGHT_RST;
			cfg_q.color  <= DRAW_COLOR_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SCREEN_WIDTH:  cfg_q.width  <= cfg_wdata;
				CFG_SCREEN_HEIGHT: cfg_q.height <= cfg_wdata;
				CFG_DRAW_COLOR:    cfg_q.color  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Commands are taken whenever the point buffer is free or about to be.
	assign cmd.ready = take;
	assign cmd_fire  = cmd.valid && take;

	crz_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (cmd_fire),
		.op       (cmd.op),
		.center_x (cmd.center_x),
		.center_y (cmd.center_y),
		.radius   (cmd.radius),
		.filled   (cmd.filled),
		.pt_load  (pt_load),
		.pt       (pt)
	);

	crz_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_load   (pt_load),
		.pt        (pt),
		.cfg       (cfg_q),
		.take      (take),
		.out_valid (pix.valid),
		.out_ready (pix.ready),
		.pixel_x   (pix.pixel_x),
		.pixel_y   (pix.pixel_y),
		.visible   (pix.visible),
		.color     (pix.color),
		.last      (pix.last)
	);

endmodule
